// ----- design/lmrs_pkg.sv -----
// ----------------------------------------------------------------------------
// LED matrix row scan driver package
// Shared constants, scan phase encoding and panel pin layout.
// ----------------------------------------------------------------------------
package lmrs_pkg;

  localparam int unsigned ROWS          = 16;
  localparam int unsigned BYTES_PER_ROW = 10;
  localparam int unsigned WAIT_W        = 16;
  localparam int unsigned BIT_W         = 3;

  localparam logic [WAIT_W-1:0] ROW_HOLD_RESET    = 16'd4000;
  localparam logic [WAIT_W-1:0] FRAME_BLANK_RESET = 16'd1300;

  // register index, taken from paddr[2]
  localparam logic REG_ROW_HOLD    = 1'b0;
  localparam logic REG_FRAME_BLANK = 1'b1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    PH_SHIFT_LOW,
    PH_SHIFT_HIGH,
    PH_HOLD,
    PH_LATCH_HIGH,
    PH_LATCH_LOW,
    PH_ENABLE,
    PH_FRAME_BLANK
  } phase_e;

  typedef struct packed {
    logic       enable_n;
    logic       latch_line;
    logic       shift_clock;
    logic       color_line;
    logic [3:0] row_address;
  } pins_t;

  localparam pins_t PINS_RESET = '{enable_n: 1'b1, latch_line: 1'b0, shift_clock: 1'b0,
                                   color_line: 1'b0, row_address: 4'd0};

endpackage

// ----- design/led_matrix_row_scan_driver.sv -----
// ----------------------------------------------------------------------------
// LED matrix row scan driver
// Takes one request per clock unless the result port stalls. An accepted
// request is registered, then its pin snapshot goes to the result register,
// with full throughput under back-to-back traffic. The rate is set by the
// single pass from the request register through the scan counters and pin
// logic to the result register; the frame store read for the next scan
// position is issued ahead from the updated counters, with writes forwarded.
// The frame store reads as zero after reset through per-entry valid bits, so
// there is no clearing pass. Writes outside the panel are dropped.
// ----------------------------------------------------------------------------
module led_matrix_row_scan_driver #(
  parameter int unsigned Rows        = lmrs_pkg::ROWS,
  parameter int unsigned BytesPerRow = lmrs_pkg::BYTES_PER_ROW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // buf_row[3:0], buf_column[7:4], pixel_byte[15:8]
  input  logic        s_axis_tuser,   // command[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // row_address[3:0], color_line[4], shift_clock[5],
                                      // latch_line[6], enable_n[7]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lmrs_pkg::*;

  localparam int unsigned RowW = $clog2(Rows);
  localparam int unsigned ColW = (BytesPerRow > 1) ? $clog2(BytesPerRow) : 1;

  logic              in_valid_q;
  cmd_e              cmd_q;
  logic [3:0]        buf_row_q;
  logic [3:0]        buf_col_q;
  logic [7:0]        pixel_q;
  logic              out_valid_q;
  logic              fire;
  logic              tick;
  logic              wr_en;
  logic [WAIT_W-1:0] row_hold_q;
  logic [WAIT_W-1:0] frame_blank_q;
  logic              cfg_wr;
  logic [RowW-1:0]   rd_row;
  logic [ColW-1:0]   rd_col;
  logic [7:0]        rd_byte;
  pins_t             pins;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign tick          = fire && (cmd_q == CMD_TICK);
  assign wr_en         = fire && (cmd_q == CMD_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q     <= cmd_e'(s_axis_tuser);
      buf_row_q <= s_axis_tdata[3:0];
      buf_col_q <= s_axis_tdata[7:4];
      pixel_q   <= s_axis_tdata[15:8];
    end
  end

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_hold_q    <= ROW_HOLD_RESET;
      frame_blank_q <= FRAME_BLANK_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROW_HOLD:    row_hold_q    <= pwdata[WAIT_W-1:0];
        REG_FRAME_BLANK: frame_blank_q <= pwdata[WAIT_W-1:0];
        default:         row_hold_q    <= row_hold_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_HOLD:    prdata = 32'(row_hold_q);
      REG_FRAME_BLANK: prdata = 32'(frame_blank_q);
      default:         prdata = '0;
    endcase
  end

  lmrs_frame_store #(
    .Rows        (Rows),
    .BytesPerRow (BytesPerRow),
    .RowW        (RowW),
    .ColW        (ColW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_row_i  (buf_row_q),
    .wr_col_i  (buf_col_q),
    .wr_data_i (pixel_q),
    .rd_row_i  (rd_row),
    .rd_col_i  (rd_col),
    .rd_byte_o (rd_byte)
  );

  lmrs_scan_ctrl #(
    .Rows        (Rows),
    .BytesPerRow (BytesPerRow),
    .RowW        (RowW),
    .ColW        (ColW)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick),
    .byte_i        (rd_byte),
    .row_hold_i    (row_hold_q),
    .frame_blank_i (frame_blank_q),
    .pins_o        (pins),
    .rd_row_o      (rd_row),
    .rd_col_o      (rd_col)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pins;

`ifndef SYNTHESIS
  a_latch_blanked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pins.latch_line |-> pins.enable_n)
    else $error("latch raised while display enabled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  a_pins_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick |=> $stable(pins))
    else $error("pins changed without a tick request");
`endif

endmodule

// ----- design/lmrs_frame_store.sv -----
// ----------------------------------------------------------------------------
// LED matrix frame store
// Byte buffer with one write and one registered read port. Per-entry valid
// bits make unwritten bytes read as zero; a write to the read address is
// forwarded.
// ----------------------------------------------------------------------------
module lmrs_frame_store #(
  parameter int unsigned Rows        = lmrs_pkg::ROWS,
  parameter int unsigned BytesPerRow = lmrs_pkg::BYTES_PER_ROW,
  parameter int unsigned RowW        = $clog2(Rows),
  parameter int unsigned ColW        = (BytesPerRow > 1) ? $clog2(BytesPerRow) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [3:0]      wr_row_i,
  input  logic [3:0]      wr_col_i,
  input  logic [7:0]      wr_data_i,
  input  logic [RowW-1:0] rd_row_i,
  input  logic [ColW-1:0] rd_col_i,
  output logic [7:0]      rd_byte_o
);
  import lmrs_pkg::*;

  localparam int unsigned Depth = Rows * BytesPerRow;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0]       mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [7:0]       rd_data_q;
  logic             rd_valid_q;
  logic             wr_ok;
  logic             hit;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;

  assign wr_ok = wr_en_i && (int'(wr_row_i) < Rows) && (int'(wr_col_i) < BytesPerRow);
  assign waddr = AddrW'(int'(wr_row_i) * BytesPerRow + int'(wr_col_i));
  assign raddr = AddrW'(int'(rd_row_i) * BytesPerRow + int'(rd_col_i));
  assign hit   = wr_ok && (waddr == raddr);

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[waddr] <= wr_data_i;
    end
    if (hit) begin
      rd_data_q <= wr_data_i;
    end else begin
      rd_data_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid_q[waddr] <= 1'b1;
      end
      rd_valid_q <= hit || valid_q[raddr];
    end
  end

  assign rd_byte_o = rd_valid_q ? rd_data_q : 8'd0;

endmodule

// ----- design/lmrs_scan_ctrl.sv -----
// ----------------------------------------------------------------------------
// LED matrix scan controller
// Row, column and bit counters, a shared timer for row hold and frame blank,
// and the panel pin register. Steps once per tick request.
// ----------------------------------------------------------------------------
module lmrs_scan_ctrl #(
  parameter int unsigned Rows        = lmrs_pkg::ROWS,
  parameter int unsigned BytesPerRow = lmrs_pkg::BYTES_PER_ROW,
  parameter int unsigned RowW        = $clog2(Rows),
  parameter int unsigned ColW        = (BytesPerRow > 1) ? $clog2(BytesPerRow) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_i,
  input  logic [7:0]                  byte_i,
  input  logic [lmrs_pkg::WAIT_W-1:0] row_hold_i,
  input  logic [lmrs_pkg::WAIT_W-1:0] frame_blank_i,
  output lmrs_pkg::pins_t             pins_o,
  output logic [RowW-1:0]             rd_row_o,
  output logic [ColW-1:0]             rd_col_o
);
  import lmrs_pkg::*;

  phase_e            phase_q, phase_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  pins_t             pin_q, pin_d;
  logic              wait_zero;
  logic              row_last;
  logic              col_last;
  logic              shift_bit;

  assign wait_zero = (wait_q == '0);
  assign row_last  = (row_q == RowW'(Rows - 1));
  assign col_last  = (col_q == ColW'(BytesPerRow - 1));
  assign shift_bit = byte_i[~bit_q];

  always_comb begin
    phase_d = phase_q;
    row_d   = row_q;
    col_d   = col_q;
    bit_d   = bit_q;
    wait_d  = wait_q;
    if (tick_i) begin
      unique case (phase_q)
        PH_SHIFT_LOW: begin
          phase_d = PH_SHIFT_HIGH;
        end
        PH_SHIFT_HIGH: begin
          phase_d = PH_SHIFT_LOW;
          if (bit_q == BIT_W'(7)) begin
            bit_d = '0;
            if (col_last) begin
              col_d   = '0;
              wait_d  = row_hold_i;
              phase_d = PH_HOLD;
            end else begin
              col_d = col_q + ColW'(1);
            end
          end else begin
            bit_d = bit_q + BIT_W'(1);
          end
        end
        PH_HOLD: begin
          if (wait_zero) begin
            phase_d = PH_LATCH_HIGH;
          end else begin
            wait_d = wait_q - WAIT_W'(1);
          end
        end
        PH_LATCH_HIGH: begin
          phase_d = PH_LATCH_LOW;
        end
        PH_LATCH_LOW: begin
          phase_d = PH_ENABLE;
        end
        PH_ENABLE: begin
          if (row_last) begin
            row_d   = '0;
            wait_d  = frame_blank_i;
            phase_d = PH_FRAME_BLANK;
          end else begin
            row_d   = row_q + RowW'(1);
            phase_d = PH_SHIFT_LOW;
          end
        end
        PH_FRAME_BLANK: begin
          if (wait_zero) begin
            row_d   = '0;
            col_d   = '0;
            bit_d   = '0;
            phase_d = PH_SHIFT_HIGH;
          end else begin
            wait_d = wait_q - WAIT_W'(1);
          end
        end
        default: begin
          phase_d = PH_SHIFT_LOW;
        end
      endcase
    end
  end

  always_comb begin
    pin_d = pin_q;
    if (tick_i) begin
      unique case (phase_q)
        PH_SHIFT_LOW: begin
          pin_d.row_address = 4'(row_q);
          pin_d.color_line  = ~shift_bit;
          pin_d.shift_clock = 1'b0;
        end
        PH_SHIFT_HIGH: begin
          pin_d.shift_clock = 1'b1;
        end
        PH_HOLD: begin
          pin_d.shift_clock = 1'b0;
          if (wait_zero) begin
            pin_d.enable_n = 1'b1;
          end
        end
        PH_LATCH_HIGH: begin
          pin_d.latch_line = 1'b1;
        end
        PH_LATCH_LOW: begin
          pin_d.latch_line = 1'b0;
        end
        PH_ENABLE: begin
          pin_d.enable_n = 1'b0;
        end
        PH_FRAME_BLANK: begin
          if (wait_zero) begin
            pin_d.enable_n    = 1'b1;
            pin_d.row_address = 4'd0;
            pin_d.color_line  = ~shift_bit;
            pin_d.shift_clock = 1'b0;
          end
        end
        default: begin
          pin_d = pin_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SHIFT_LOW;
      row_q   <= '0;
      col_q   <= '0;
      bit_q   <= '0;
      wait_q  <= '0;
      pin_q   <= PINS_RESET;
    end else begin
      phase_q <= phase_d;
      row_q   <= row_d;
      col_q   <= col_d;
      bit_q   <= bit_d;
      wait_q  <= wait_d;
      pin_q   <= pin_d;
    end
  end

  assign pins_o   = pin_q;
  assign rd_row_o = row_d;
  assign rd_col_o = col_d;

endmodule

// ----- verif/lmrs_scan_checker.sv -----
// ----------------------------------------------------------------------------
// LED matrix row scan driver checker
// Watches the request, result and register ports, runs its own scan model
// over every accepted request and compares each pin snapshot field by field.
// ----------------------------------------------------------------------------
module lmrs_scan_checker
  import lmrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // buf_row[3:0], buf_column[7:4], pixel_byte[15:8]
  input  logic        s_axis_tuser,   // command[0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // row_address[3:0], color_line[4], shift_clock[5],
                                      // latch_line[6], enable_n[7]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned ticks_o,
  output int unsigned stores_o,
  output int unsigned dropped_o,
  output int unsigned latches_o,
  output int unsigned frames_o,
  output int unsigned results_o
);

  typedef enum logic [2:0] {
    SCAN_SHIFT_LOW,
    SCAN_SHIFT_HIGH,
    SCAN_HOLD,
    SCAN_BLANK_ROW,
    SCAN_LATCH_HIGH,
    SCAN_LATCH_LOW,
    SCAN_UNBLANK,
    SCAN_FRAME_WAIT
  } scan_step_e;

  logic [7:0]   pixel_mem [ROWS*BYTES_PER_ROW];
  scan_step_e   scan_step;
  int unsigned  row_idx, col_idx, bit_idx, wait_left;
  logic [15:0]  hold_cfg, blank_cfg;
  pins_t        pins;
  pins_t        expected_pins [$];
  pins_t        got, want;
  int unsigned  mismatches;

  function automatic void advance_scan();
    bit         again;
    logic [7:0] pix;
    do begin
      again = 1'b0;
      case (scan_step)
        SCAN_SHIFT_LOW: begin
          pix = pixel_mem[row_idx*BYTES_PER_ROW + col_idx];
          pins.row_address = row_idx[3:0];
          pins.color_line  = ~pix[7 - bit_idx];
          pins.shift_clock = 1'b0;
          scan_step = SCAN_SHIFT_HIGH;
        end
        SCAN_SHIFT_HIGH: begin
          pins.shift_clock = 1'b1;
          scan_step = SCAN_SHIFT_LOW;
          bit_idx++;
          if (bit_idx >= 8) begin
            bit_idx = 0;
            col_idx++;
            if (col_idx >= BYTES_PER_ROW) begin
              col_idx   = 0;
              wait_left = hold_cfg;
              scan_step = SCAN_HOLD;
            end
          end
        end
        SCAN_HOLD: begin
          pins.shift_clock = 1'b0;
          if (wait_left == 0) begin
            scan_step = SCAN_BLANK_ROW;
            again = 1'b1;
          end else begin
            wait_left--;
          end
        end
        SCAN_BLANK_ROW: begin
          pins.shift_clock = 1'b0;
          pins.enable_n    = 1'b1;
          scan_step = SCAN_LATCH_HIGH;
        end
        SCAN_LATCH_HIGH: begin
          pins.latch_line = 1'b1;
          latches_o++;
          scan_step = SCAN_LATCH_LOW;
        end
        SCAN_LATCH_LOW: begin
          pins.latch_line = 1'b0;
          scan_step = SCAN_UNBLANK;
        end
        SCAN_UNBLANK: begin
          pins.enable_n = 1'b0;
          if (row_idx + 1 >= ROWS) begin
            wait_left = blank_cfg;
            scan_step = SCAN_FRAME_WAIT;
          end else begin
            row_idx++;
            scan_step = SCAN_SHIFT_LOW;
          end
        end
        default: begin
          if (wait_left == 0) begin
            pins.enable_n = 1'b1;
            row_idx = 0;
            col_idx = 0;
            bit_idx = 0;
            frames_o++;
            scan_step = SCAN_SHIFT_LOW;
            again = 1'b1;
          end else begin
            wait_left--;
          end
        end
      endcase
    end while (again);
  endfunction

  function automatic void take_request(input cmd_e cmd, input logic [3:0] row,
                                       input logic [3:0] col, input logic [7:0] pix);
    if (cmd == CMD_TICK) begin
      ticks_o++;
      advance_scan();
    end else if (row < ROWS && col < BYTES_PER_ROW) begin
      stores_o++;
      pixel_mem[row*BYTES_PER_ROW + col] = pix;
    end else begin
      dropped_o++;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("pin %s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (pixel_mem[i]) pixel_mem[i] = 8'h00;
      scan_step = SCAN_SHIFT_LOW;
      row_idx   = 0;
      col_idx   = 0;
      bit_idx   = 0;
      wait_left = 0;
      pins      = PINS_RESET;
      hold_cfg  = ROW_HOLD_RESET;
      blank_cfg = FRAME_BLANK_RESET;
      expected_pins.delete();
      mismatches = 0;
      ticks_o    = 0;
      stores_o   = 0;
      dropped_o  = 0;
      latches_o  = 0;
      frames_o   = 0;
      results_o  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ROW_HOLD) hold_cfg = pwdata[15:0];
        else blank_cfg = pwdata[15:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_request(cmd_e'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[7:4],
                     s_axis_tdata[15:8]);
        expected_pins.push_back(pins);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = pins_t'(m_axis_tdata);
        results_o++;
        if (expected_pins.size() == 0) begin
          $error("unexpected pin snapshot %02h with no request outstanding", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_pins.pop_front();
          check_field("row_address", want.row_address, got.row_address);
          check_field("color_line", want.color_line, got.color_line);
          check_field("shift_clock", want.shift_clock, got.shift_clock);
          check_field("latch_line", want.latch_line, got.latch_line);
          check_field("enable_n", want.enable_n, got.enable_n);
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_pins.size();
  end

endmodule

// ----- verif/led_matrix_row_scan_driver_tb.sv -----
// ----------------------------------------------------------------------------
// LED matrix row scan driver testbench
// Drives buffer writes and scan ticks through several register settings and
// flow-control patterns, including a long result stall; the checker predicts
// and compares every pin snapshot.
// ----------------------------------------------------------------------------
module led_matrix_row_scan_driver_tb;
  import lmrs_pkg::*;

  localparam int unsigned STALL_LIMIT    = 3000;
  localparam int unsigned HOLDOFF_CYCLES = 400;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = CMD_WRITE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count, pending, ticks, stores, dropped, latches, frames, results;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int unsigned holdoff_reqs = 0;
  int unsigned holdoff_seen = 0;
  int unsigned holdoff_left = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  led_matrix_row_scan_driver dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lmrs_scan_checker scan_check (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending), .ticks_o(ticks), .stores_o(stores),
    .dropped_o(dropped), .latches_o(latches), .frames_o(frames), .results_o(results)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (holdoff_left != 0) begin
      m_axis_tready <= 1'b0;
      holdoff_left--;
    end else if (holdoff_seen != holdoff_reqs) begin
      holdoff_seen = holdoff_reqs;
      holdoff_left = HOLDOFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(input cmd_e cmd, input logic [3:0] row, input logic [3:0] col,
                              input logic [7:0] pix);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {pix, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random_request();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 92) begin
      send_request(CMD_TICK, 4'($urandom), 4'($urandom), 8'($urandom));
    end else if (roll < 98) begin
      send_request(CMD_WRITE, 4'($urandom), 4'($urandom_range(BYTES_PER_ROW - 1)),
                   8'($urandom));
    end else begin
      send_request(CMD_WRITE, 4'($urandom), 4'($urandom_range(15, BYTES_PER_ROW)),
                   8'($urandom));
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic index, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [15:0] hold, input logic [15:0] blank,
                           input idle_mode_e mode, input int unsigned count,
                           input bit pressure);
    drain();
    write_register(REG_ROW_HOLD, hold);
    write_register(REG_FRAME_BLANK, blank);
    gap_pct    = (mode == IDLE_SEND) ? 55 : (mode == IDLE_BOTH) ? 35 : 0;
    stall_pct <= (mode == IDLE_RECV) ? 55 : (mode == IDLE_BOTH) ? 35 : 0;
    if (pressure) holdoff_reqs <= holdoff_reqs + 1;
    repeat (count) send_random_request();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values, empty frame store
    send_request(CMD_TICK, 4'h0, 4'h0, 8'h00);
    send_request(CMD_WRITE, 4'h0, 4'h0, 8'hA5);
    send_request(CMD_TICK, 4'hF, 4'hF, 8'hFF);
    send_request(CMD_TICK, 4'h0, 4'h0, 8'h00);
    send_request(CMD_WRITE, 4'hF, 4'd9, 8'hFF);
    send_request(CMD_WRITE, 4'h0, 4'd9, 8'h00);
    send_request(CMD_WRITE, 4'hF, 4'h0, 8'h80);
    send_request(CMD_WRITE, 4'h3, 4'd10, 8'hFF);
    send_request(CMD_WRITE, 4'h7, 4'hF, 8'hAA);
    send_request(CMD_WRITE, 4'h0, 4'h1, 8'h5A);
    send_request(CMD_WRITE, 4'hF, 4'hF, 8'hFF);
    repeat (12) send_request(CMD_TICK, 4'h0, 4'h0, 8'h00);

    run_phase(16'hFFFF, 16'hFFFF, IDLE_NONE, 100, 1'b0);
    run_phase(16'd0, 16'd0, IDLE_SEND, 400, 1'b0);
    run_phase(16'd2, 16'd1, IDLE_RECV, 400, 1'b1);
    run_phase(16'd1, 16'd5, IDLE_BOTH, 400, 1'b0);
    run_phase(16'($urandom_range(6)), 16'($urandom_range(6)), IDLE_NONE, 400, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    $display("covered %0d ticks, %0d buffer writes and %0d out-of-range writes",
             ticks, stores, dropped);
    $display("saw %0d row latches and %0d frame restarts over %0d checked snapshots",
             latches, frames, results);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- led_matrix_row_scan_driver.f -----
design/lmrs_pkg.sv
design/lmrs_frame_store.sv
design/lmrs_scan_ctrl.sv
design/led_matrix_row_scan_driver.sv
verif/lmrs_scan_checker.sv
verif/led_matrix_row_scan_driver_tb.sv
